// ===== hdl/gbc_pkg.sv =====
// shared types and constants for the gyro bias calibrator
package gbc_pkg;

  localparam int WINDOW_SAMPLES_DEF = 128;
  localparam int AXES               = 3;
  localparam int SAMPLE_W           = 16;
  localparam int OUT_W              = SAMPLE_W + 1;
  localparam int TICK_W             = 32;
  localparam int CFG_W              = 32;
  localparam int CFG_INDEX_W        = 8;
  localparam int ENTRY_W            = AXES * SAMPLE_W;

  localparam logic [CFG_W-1:0] LIMIT_RESET = CFG_W'(4000);
  localparam logic [CFG_W-1:0] TICK_RESET  = CFG_W'(1);

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_VARIANCE_LIMIT = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_EARLIEST_TICK  = CFG_INDEX_W'(1);

  typedef logic [ENTRY_W-1:0] entry_t;

  // load strobes for the arithmetic stages of an axis lane
  typedef struct packed {
    logic go2;
    logic go3;
    logic go4;
    logic go5;
  } stage_go_t;

endpackage

// ===== hdl/gbc_cell.sv =====
// one window cell: holds a three-axis sample and passes it on per item
module gbc_cell (
  input  logic            clk,
  input  logic            shift,
  input  gbc_pkg::entry_t d,
  output gbc_pkg::entry_t q
);
  import gbc_pkg::*;

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

// ===== hdl/gbc_axis.sv =====
// per-axis lane: running sums, stillness test and bias candidate
module gbc_axis #(
  parameter int WINDOW_SAMPLES = gbc_pkg::WINDOW_SAMPLES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  gbc_pkg::stage_go_t                  go,
  input  logic signed [gbc_pkg::SAMPLE_W-1:0] x,
  input  logic signed [gbc_pkg::SAMPLE_W-1:0] old,
  input  logic        [gbc_pkg::CFG_W-1:0]    limit,
  output logic                                still,
  output logic signed [gbc_pkg::SAMPLE_W-1:0] bias
);
  import gbc_pkg::*;

  localparam int LOG_N = $clog2(WINDOW_SAMPLES);
  localparam int DIF_W = SAMPLE_W + 1;
  localparam int SQV_W = 2 * SAMPLE_W - 1;
  localparam int SUM_W = SAMPLE_W + LOG_N;
  localparam int SQ_W  = SQV_W + LOG_N;
  localparam int P_W   = 2 * SUM_W - 1;
  localparam int T_W   = SQ_W + 1;
  localparam int TH_W  = T_W + LOG_N + 1;
  localparam int REC_K = SUM_W + LOG_N;
  localparam int M_W   = SUM_W + 2;
  localparam int QP_W  = SUM_W + M_W;
  localparam int Q_W   = SAMPLE_W + 1;
  // reciprocal of the window length, exact for any magnitude below 2^SUM_W
  localparam logic [63:0]    REC_M  = (64'd1 << REC_K) / 64'(WINDOW_SAMPLES) + 64'd1;
  localparam logic [M_W-1:0] REC_MV = M_W'(REC_M);

  logic signed [2*SAMPLE_W-1:0] x_sq;
  logic signed [2*SAMPLE_W-1:0] o_sq;
  logic        [SQV_W-1:0]      sq_new;
  logic        [SQV_W-1:0]      sq_old;
  logic signed [DIF_W-1:0]      dif;

  logic signed [SUM_W-1:0]      sum;
  logic        [SQ_W-1:0]       sq_sum;

  logic signed [2*SUM_W-1:0]    sum_sq;
  logic        [SUM_W-1:0]      sum_u;
  logic        [P_W-1:0]        pp;
  logic                         ge;
  logic        [T_W-1:0]        t1;
  logic        [SUM_W-1:0]      mag;
  logic                         neg4;

  logic        [TH_W-1:0]       thr;
  logic        [QP_W-1:0]       qp;
  logic        [QP_W-1:0]       qp5;
  logic                         neg5;
  logic        [Q_W-1:0]        q;
  logic        [Q_W-1:0]        b;

  assign x_sq = x * x;
  assign o_sq = old * old;

  // squares and sample change
  always_ff @(posedge clk) begin
    if (go.go2) begin
      sq_new <= x_sq[SQV_W-1:0];
      sq_old <= o_sq[SQV_W-1:0];
      dif    <= DIF_W'(x) - DIF_W'(old);
    end
  end

  // running sums over the window
  always_ff @(posedge clk) begin
    if (rst) begin
      sum    <= '0;
      sq_sum <= '0;
    end else if (go.go3) begin
      sum    <= sum + SUM_W'(dif);
      sq_sum <= sq_sum + SQ_W'(sq_new) - SQ_W'(sq_old);
    end
  end

  assign sum_sq = sum * sum;
  assign sum_u  = sum;

  // spread < limit  <=>  sq_sum < limit  or  sum^2 >= N * (sq_sum - limit + 1)
  always_ff @(posedge clk) begin
    if (go.go4) begin
      pp   <= sum_sq[P_W-1:0];
      ge   <= sq_sum >= SQ_W'(limit);
      t1   <= T_W'(sq_sum) - T_W'(limit) + T_W'(1);
      mag  <= sum[SUM_W-1] ? (~sum_u + SUM_W'(1)) : sum_u;
      neg4 <= sum[SUM_W-1];
    end
  end

  assign thr = TH_W'(t1) * TH_W'(WINDOW_SAMPLES);
  assign qp  = QP_W'(mag) * QP_W'(REC_MV);

  always_ff @(posedge clk) begin
    if (go.go5) begin
      still <= !ge || (TH_W'(pp) >= thr);
      qp5   <= qp;
      neg5  <= neg4;
    end
  end

  // mean truncated toward zero
  assign q    = qp5[REC_K +: Q_W];
  assign b    = neg5 ? (~q + Q_W'(1)) : q;
  assign bias = signed'(b[SAMPLE_W-1:0]);

endmodule

// ===== hdl/gyro_bias_calibrator.sv =====
// top level of the gyro bias calibrator: window chain, pipeline control, bias latch
//
//  channel   signals                                   dir  payload
//  --------  ----------------------------------------  ---  ----------------------------
//  in        in_valid / in_ready                       in   rate_x, rate_y, rate_z, tick_now
//  out       out_valid / out_ready                     out  corrected_x/_y/_z, calibrated
//  cfg       cfg_valid / cfg_ready                     in   cfg_index, cfg_data
//
// one item per clock sustained while the receiver takes results; the path has
// six register stages, the first loaded at the accepting edge:
// window shift, squares, running sums, square of the sum, stillness compare,
// bias latch and output subtract
// reset clears the valid bits, the window counter, the sums, the latched bias and the
// registers to their defaults; the window cells are not cleared and no sweep is needed
// a low out_ready backs the pipeline up stage by stage, so empty stages still fill
// cfg_ready is always high; writes are meant for when no item is in flight
module gyro_bias_calibrator #(
  parameter int WINDOW_SAMPLES = gbc_pkg::WINDOW_SAMPLES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,

  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [gbc_pkg::SAMPLE_W-1:0]    rate_x,
  input  logic signed [gbc_pkg::SAMPLE_W-1:0]    rate_y,
  input  logic signed [gbc_pkg::SAMPLE_W-1:0]    rate_z,
  input  logic        [gbc_pkg::TICK_W-1:0]      tick_now,

  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [gbc_pkg::OUT_W-1:0]       corrected_x,
  output logic signed [gbc_pkg::OUT_W-1:0]       corrected_y,
  output logic signed [gbc_pkg::OUT_W-1:0]       corrected_z,
  output logic                                   calibrated,

  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic        [gbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic        [gbc_pkg::CFG_W-1:0]       cfg_data
);
  import gbc_pkg::*;

  localparam int LOG_N = $clog2(WINDOW_SAMPLES);

  // configuration registers
  logic [CFG_W-1:0] variance_limit;
  logic [CFG_W-1:0] earliest_tick;

  // handshake chain through the stages
  logic [5:1] v;
  logic [6:1] rdy;
  logic [6:1] go;
  stage_go_t  lane_go;

  // window chain and fill state
  entry_t            chain [WINDOW_SAMPLES];
  entry_t            new_entry;
  entry_t            oldest;
  logic [LOG_N-1:0]  write_pointer;
  logic              window_full;
  logic              wrap;

  // per-stage carried payload
  logic signed [SAMPLE_W-1:0] x1 [AXES];
  logic signed [SAMPLE_W-1:0] x2 [AXES];
  logic signed [SAMPLE_W-1:0] x3 [AXES];
  logic signed [SAMPLE_W-1:0] x4 [AXES];
  logic signed [SAMPLE_W-1:0] x5 [AXES];
  logic signed [SAMPLE_W-1:0] old1 [AXES];
  logic [TICK_W-1:0] tick1, tick2, tick3, tick4, tick5;
  logic              full1, full2, full3, full4, full5;

  // lane results and the latch
  logic [AXES-1:0]            still;
  logic signed [SAMPLE_W-1:0] bias_cand [AXES];
  logic signed [SAMPLE_W-1:0] latched_bias [AXES];
  logic signed [SAMPLE_W-1:0] bias_eff [AXES];
  logic                       bias_found;
  logic                       latch;
  logic signed [OUT_W-1:0]    corr [AXES];

  // ready flows back: a stage takes data when it is empty or its successor takes
  assign rdy[6] = !out_valid || out_ready;
  assign rdy[5] = !v[5] || rdy[6];
  assign rdy[4] = !v[4] || rdy[5];
  assign rdy[3] = !v[3] || rdy[4];
  assign rdy[2] = !v[2] || rdy[3];
  assign rdy[1] = !v[1] || rdy[2];
  assign in_ready = rdy[1];

  assign go[1] = in_valid && rdy[1];
  assign go[2] = v[1] && rdy[2];
  assign go[3] = v[2] && rdy[3];
  assign go[4] = v[3] && rdy[4];
  assign go[5] = v[4] && rdy[5];
  assign go[6] = v[5] && rdy[6];

  assign lane_go.go2 = go[2];
  assign lane_go.go3 = go[3];
  assign lane_go.go4 = go[4];
  assign lane_go.go5 = go[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rdy[1]) v[1] <= in_valid;
      if (rdy[2]) v[2] <= v[1];
      if (rdy[3]) v[3] <= v[2];
      if (rdy[4]) v[4] <= v[3];
      if (rdy[5]) v[5] <= v[4];
      if (rdy[6]) out_valid <= v[5];
    end
  end

  // configuration writes; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      variance_limit <= LIMIT_RESET;
      earliest_tick  <= TICK_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_VARIANCE_LIMIT: variance_limit <= cfg_data;
        REG_EARLIEST_TICK:  earliest_tick  <= cfg_data;
        default: ;
      endcase
    end
  end

  // window: a row of cells that shifts once per accepted item,
  // so the last cell holds the sample that leaves the window
  assign new_entry = {rate_z, rate_y, rate_x};

  gbc_cell u_cell_head (
    .clk   (clk),
    .shift (go[1]),
    .d     (new_entry),
    .q     (chain[0])
  );

  for (genvar i = 1; i < WINDOW_SAMPLES; i++) begin : g_cell
    gbc_cell u_cell (
      .clk   (clk),
      .shift (go[1]),
      .d     (chain[i-1]),
      .q     (chain[i])
    );
  end

  assign oldest = chain[WINDOW_SAMPLES-1];
  assign wrap   = (write_pointer == LOG_N'(WINDOW_SAMPLES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      window_full   <= 1'b0;
    end else if (go[1]) begin
      write_pointer <= wrap ? '0 : write_pointer + LOG_N'(1);
      if (wrap) begin
        window_full <= 1'b1;
      end
    end
  end

  // stage 1: sample in, leaving sample out (zero until the window has filled)
  always_ff @(posedge clk) begin
    if (go[1]) begin
      x1[0] <= rate_x;
      x1[1] <= rate_y;
      x1[2] <= rate_z;
      for (int a = 0; a < AXES; a++) begin
        old1[a] <= window_full ? signed'(oldest[SAMPLE_W*a +: SAMPLE_W]) : '0;
      end
      tick1 <= tick_now;
      full1 <= window_full || wrap;
    end
  end

  // stages 2 to 5: carry the sample, tick and fill flag beside the lanes
  always_ff @(posedge clk) begin
    if (go[2]) begin
      x2    <= x1;
      tick2 <= tick1;
      full2 <= full1;
    end
    if (go[3]) begin
      x3    <= x2;
      tick3 <= tick2;
      full3 <= full2;
    end
    if (go[4]) begin
      x4    <= x3;
      tick4 <= tick3;
      full4 <= full3;
    end
    if (go[5]) begin
      x5    <= x4;
      tick5 <= tick4;
      full5 <= full4;
    end
  end

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    gbc_axis #(
      .WINDOW_SAMPLES (WINDOW_SAMPLES)
    ) u_axis (
      .clk   (clk),
      .rst   (rst),
      .go    (lane_go),
      .x     (x1[a]),
      .old   (old1[a]),
      .limit (variance_limit),
      .still (still[a]),
      .bias  (bias_cand[a])
    );
  end

  // stage 6: latch the bias once, then subtract the bias as it stands after the test
  assign latch = go[6] && full5 && !bias_found && (&still) && (tick5 > earliest_tick);

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      bias_eff[a] = latch ? bias_cand[a] : latched_bias[a];
      corr[a]     = OUT_W'(x5[a]) - OUT_W'(bias_eff[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bias_found <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        latched_bias[a] <= '0;
      end
    end else if (latch) begin
      bias_found   <= 1'b1;
      latched_bias <= bias_cand;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (go[6]) begin
      corrected_x <= corr[0];
      corrected_y <= corr[1];
      corrected_z <= corr[2];
      calibrated  <= bias_found || latch;
    end
  end

endmodule

// ===== dv/tb.sv =====
// testbench for the gyro bias calibrator: directed and random samples, bias latch and checks
module tb;
  import gbc_pkg::*;

  // window depth of the block as built with its default parameter
  localparam int WIN             = WINDOW_SAMPLES_DEF;
  // receiver hold-off that backs the pipeline up into the input
  localparam int HOLD_OFF_CYCLES = 120;
  // quiet cycles after the last result: pipeline depth plus margin
  localparam int DRAIN_CYCLES    = 10;
  // cycles without any handshake before the run is declared hung
  localparam int WATCHDOG_LIMIT  = 3000;

  // register indexes that decode to nothing
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LOW = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_TOP = '1;

  typedef struct {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
    logic                    cal;
  } correction_t;

  logic clk = 1'b0;
  logic rst;

  logic                     in_valid;
  logic                     in_ready;
  logic signed [SAMPLE_W-1:0] rate_x;
  logic signed [SAMPLE_W-1:0] rate_y;
  logic signed [SAMPLE_W-1:0] rate_z;
  logic        [TICK_W-1:0] tick_now;

  logic                     out_valid;
  logic                     out_ready;
  logic signed [OUT_W-1:0]  corrected_x;
  logic signed [OUT_W-1:0]  corrected_y;
  logic signed [OUT_W-1:0]  corrected_z;
  logic                     calibrated;

  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_INDEX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]         cfg_data;

  gyro_bias_calibrator dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rate_x      (rate_x),
    .rate_y      (rate_y),
    .rate_z      (rate_z),
    .tick_now    (tick_now),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .corrected_x (corrected_x),
    .corrected_y (corrected_y),
    .corrected_z (corrected_z),
    .calibrated  (calibrated),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor state: the window, running sums and the bias latch
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] limit_reg    = LIMIT_RESET;
  logic [CFG_W-1:0] earliest_reg = TICK_RESET;

  shortint window_hist [WIN][AXES];
  int      wr_ptr       = 0;
  bit      window_full  = 1'b0;
  longint  axis_sum [AXES] = '{default: 0};
  longint  axis_sq  [AXES] = '{default: 0};
  shortint bias     [AXES] = '{default: 0};
  bit      bias_latched = 1'b0;
  logic [TICK_W-1:0] latch_tick = '0;

  correction_t pending_corrections [$];
  correction_t oldest;

  int items_sent      = 0;
  int results_checked = 0;
  int mismatches      = 0;
  int hold_offs_done  = 0;
  int burst_left      = 0;
  int idle_cycles     = 0;
  bit hold_off_request = 1'b0;

  // corner values for the directed part
  shortint           corner_rates [6] = '{32767, -32768, 0, -1, 21845, -21846};
  logic [TICK_W-1:0] corner_ticks [4] = '{32'h0, 32'h1, 32'h2, 32'hFFFF_FFFF};

  // advance the window by one sample and queue the corrected output it yields
  function automatic void predict_correction(shortint sx, shortint sy, shortint sz,
                                             logic [TICK_W-1:0] t);
    shortint     smp [AXES];
    longint      spread;
    longint      lim;
    bit          still;
    correction_t due;
    smp[0] = sx;
    smp[1] = sy;
    smp[2] = sz;
    // the oldest entry leaves the sums only once the window has wrapped
    for (int a = 0; a < AXES; a++) begin
      if (window_full) begin
        axis_sum[a] -= window_hist[wr_ptr][a];
        axis_sq[a]  -= longint'(window_hist[wr_ptr][a]) * window_hist[wr_ptr][a];
      end
      window_hist[wr_ptr][a] = smp[a];
      axis_sum[a] += smp[a];
      axis_sq[a]  += longint'(smp[a]) * smp[a];
    end
    wr_ptr++;
    if (wr_ptr >= WIN) begin
      wr_ptr      = 0;
      window_full = 1'b1;
    end
    // stillness test at full width, strict on both limit and tick
    if (window_full && !bias_latched) begin
      still = 1'b1;
      lim   = limit_reg;
      for (int a = 0; a < AXES; a++) begin
        spread = axis_sq[a] - (axis_sum[a] * axis_sum[a]) / WIN;
        if (!(spread < lim)) still = 1'b0;
      end
      if (still && t > earliest_reg) begin
        // signed division truncates toward zero
        for (int a = 0; a < AXES; a++) bias[a] = shortint'(axis_sum[a] / WIN);
        bias_latched = 1'b1;
        latch_tick   = t;
      end
    end
    // output uses the bias as it stands after this step's test
    due.x   = OUT_W'(int'(sx) - int'(bias[0]));
    due.y   = OUT_W'(int'(sy) - int'(bias[1]));
    due.z   = OUT_W'(int'(sz) - int'(bias[2]));
    due.cal = bias_latched;
    pending_corrections.push_back(due);
  endfunction

  function automatic void note_error(string msg);
    if (mismatches < 10) $display("%s", msg);
    mismatches++;
  endfunction

  function automatic shortint jitter(shortint center, int amp);
    return shortint'(int'(center) + int'($urandom_range(0, 2 * amp)) - amp);
  endfunction

  // ---------------------------------------------------------------------------
  // drivers: everything changes on the falling edge
  // ---------------------------------------------------------------------------

  // offer one sample; bursts of back-to-back items with random gaps between them
  task automatic send_sample(shortint sx, shortint sy, shortint sz, logic [TICK_W-1:0] t);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 5);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    rate_x   <= sx;
    rate_y   <= sy;
    rate_z   <= sz;
    tick_now <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_correction(sx, sy, sz, t);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_noise(logic [TICK_W-1:0] t);
    send_sample(shortint'($urandom), shortint'($urandom), shortint'($urandom), t);
  endtask

  // stop offering and let every outstanding result come back
  task automatic drain_pipeline();
    in_valid  <= 1'b0;
    burst_left = 0;
    while (pending_corrections.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // register write; only called with the pipeline drained
  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_VARIANCE_LIMIT: limit_reg    = value;
      REG_EARLIEST_TICK:  earliest_reg = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes and bit patterns with reset register values; window not yet full
  task automatic test_field_extremes();
    for (int i = 0; i < 18; i++)
      send_sample(corner_rates[i % 6], corner_rates[(i + 2) % 6],
                  corner_rates[(i + 4) % 6], corner_ticks[i % 4]);
    drain_pipeline();
  endtask

  // zero limit: spread is never negative, so wild samples through the wrap never latch
  task automatic test_never_still();
    write_register(REG_VARIANCE_LIMIT, '0);
    write_register(REG_EARLIEST_TICK, '0);
    for (int i = 0; i < 130; i++) send_noise($urandom);
    drain_pipeline();
  endtask

  // quiet window with widest limit, but no tick can pass the largest gate
  task automatic test_tick_gate();
    shortint cx;
    shortint cy;
    shortint cz;
    write_register(REG_VARIANCE_LIMIT, '1);
    write_register(REG_EARLIEST_TICK, '1);
    // writes to undecoded indexes must leave both registers alone
    write_register(REG_UNUSED_LOW, '0);
    write_register(REG_UNUSED_TOP, '0);
    cx = shortint'(int'($urandom_range(0, 20000)) - 10000);
    cy = shortint'(int'($urandom_range(0, 20000)) - 10000);
    cz = shortint'(int'($urandom_range(0, 20000)) - 10000);
    for (int i = 0; i < 140; i++)
      send_sample(jitter(cx, 3), jitter(cy, 3), jitter(cz, 3),
                  (i % 16 == 0) ? corner_ticks[3] : $urandom);
    drain_pipeline();
  endtask

  // still window with x and y near the rails; tick equal to the gate holds off, first greater tick
  // latches once every spread is under the limit
  task automatic test_bias_latch();
    logic [TICK_W-1:0] gate_tick;
    shortint cx;
    shortint cy;
    shortint cz;
    int amp;
    int n;
    gate_tick = $urandom_range(1000, 32'h7FFF_FFFF);
    write_register(REG_VARIANCE_LIMIT, $urandom_range(1500, 4000));
    write_register(REG_EARLIEST_TICK, gate_tick);
    cx  = shortint'($urandom_range(25000, 32760));
    cy  = shortint'(-int'($urandom_range(25000, 32760)));
    cz  = shortint'(int'($urandom_range(0, 6000)) - 3000);
    amp = $urandom_range(2, 7);
    // a couple of spikes break the quiet run early on
    send_noise(gate_tick);
    send_noise(gate_tick);
    for (int i = 0; i < 140; i++)
      send_sample(jitter(cx, amp), jitter(cy, amp), jitter(cz, amp), gate_tick);
    // past the gate; shrink the jitter until the window is quiet enough
    n = 0;
    while (!bias_latched) begin
      if (n % 40 == 39 && amp > 0) amp--;
      send_sample(jitter(cx, amp), jitter(cy, amp), jitter(cz, amp), gate_tick + 1 + n);
      n++;
    end
    drain_pipeline();
  endtask

  // bias frozen: register writes do nothing, outputs swing to the widest differences;
  // a long receiver hold-off backs the block up while samples keep coming
  task automatic test_after_latch();
    write_register(REG_VARIANCE_LIMIT, '0);
    write_register(REG_EARLIEST_TICK, '1);
    send_sample(32767, 32767, 32767, '0);
    send_sample(-32768, -32768, -32768, '1);
    send_sample(-32768, 32767, 0, $urandom);
    send_sample(32767, -32768, -1, $urandom);
    for (int i = 0; i < 110; i++) begin
      if (i == 20) hold_off_request = 1'b1;
      send_noise($urandom);
    end
    drain_pipeline();
  endtask

  // ---------------------------------------------------------------------------
  // receiver: stall pattern changes at random, plus one long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    int mode;
    int span;
    out_ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 96);
      for (int i = 0; i < span; i++) begin
        @(negedge clk);
        if (hold_off_request) begin
          out_ready <= 1'b0;
          repeat (HOLD_OFF_CYCLES) @(negedge clk);
          hold_off_request = 1'b0;
          hold_offs_done++;
        end
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= (i % 3) != 0;
          default: out_ready <= $urandom_range(0, 3) == 0;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result check against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_corrections.size() == 0) begin
        note_error($sformatf("result with nothing expected: x=%0d y=%0d z=%0d cal=%0b",
                             corrected_x, corrected_y, corrected_z, calibrated));
      end else begin
        oldest = pending_corrections.pop_front();
        if (corrected_x !== oldest.x || corrected_y !== oldest.y ||
            corrected_z !== oldest.z || calibrated !== oldest.cal)
          note_error($sformatf({"result %0d mismatch: expected x=%0d y=%0d z=%0d cal=%0b,",
                                " got x=%0d y=%0d z=%0d cal=%0b"},
                               results_checked, oldest.x, oldest.y, oldest.z, oldest.cal,
                               corrected_x, corrected_y, corrected_z, calibrated));
        results_checked++;
      end
    end
  end

  // watchdog: any handshake on any channel resets the count
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               idle_cycles, pending_corrections.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    rate_x    = '0;
    rate_y    = '0;
    rate_z    = '0;
    tick_now  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_field_extremes();
    test_never_still();
    test_tick_gate();
    test_bias_latch();
    test_after_latch();

    if (pending_corrections.size() != 0)
      note_error($sformatf("%0d results never arrived", pending_corrections.size()));
    $display("ran %0d samples, checked %0d results, %0d receiver hold-offs",
             items_sent, results_checked, hold_offs_done);
    $display("bias latched at tick %0d as x=%0d y=%0d z=%0d, mismatches %0d",
             latch_tick, bias[0], bias[1], bias[2], mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
